[src/ksg_pkg.sv]
// shared types and constants for the kronecker symbol / gcd block
`timescale 1ns / 1ps

package ksg_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);
	localparam logic [OPERAND_WIDTH-1:0] OPND_ONE = OPERAND_WIDTH'(1);
	localparam logic [OPERAND_WIDTH-1:0] OPND_ZERO = '0;

	// residues that flip the sign of the symbol
	localparam logic [2:0] MOD8_THREE = 3'd3;
	localparam logic [2:0] MOD8_FIVE = 3'd5;
	localparam logic [1:0] MOD4_THREE = 2'd3;

	localparam logic signed [1:0] SYM_POS = 2'sb01;
	localparam logic signed [1:0] SYM_NEG = 2'sb11;
	localparam logic signed [1:0] SYM_ZERO = 2'sb00;

	typedef struct packed {
		logic [OPERAND_WIDTH-1:0] value_a;
		logic [OPERAND_WIDTH-1:0] value_b;
	} ksg_arg_t;

	typedef struct packed {
		logic signed [1:0] symbol;
		logic [OPERAND_WIDTH-1:0] common_divisor;
		logic not_coprime;
		logic invalid;
	} ksg_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STRIP,
		ST_LOOP,
		ST_DIV,
		ST_FIN
	} ksg_state_t;

endpackage

[src/kronecker_symbol_or_gcd.sv]
// kronecker symbol or gcd of two unsigned operands, iterative datapath
`timescale 1ns / 1ps

// Usage:
// An operand pair enters on the arg channel (arg_valid / arg_stall / arg) and
// one result leaves on the res channel (res_valid / res_stall / res).
// arg_stall is high from the accepting edge until the result has been moved
// into the output register; one pair is worked on at a time.
// Each remainder step runs a restoring divider that retires one dividend bit
// per cycle; that divider sets the rate. The block goes back to idle as it
// loads the output register, so a new pair can be taken in the cycle where
// res_valid first goes high.
// The output register holds a finished result while res_stall is high; the
// next pair is taken as soon as the result is in that register, so a waiting
// receiver only holds back the block once a second result is ready.
// Reset (arst_n low) empties the output register and returns to idle; no
// state is kept between pairs.
module kronecker_symbol_or_gcd
	import ksg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     arg_valid,
	output logic     arg_stall,
	input  ksg_arg_t arg,
	output logic     res_valid,
	input  logic     res_stall,
	output ksg_res_t res
);

	localparam int W = OPERAND_WIDTH;

	ksg_state_t state_q, state_d;
	logic res_valid_q, res_valid_d;
	ksg_res_t res_q, res_d;

	logic [W-1:0] x_q, x_d;
	logic [W-1:0] y_q, y_d;
	logic [W-1:0] rem_q, rem_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] twos_q, twos_d;
	logic [2:0] a8_q, a8_d;
	logic neg_q, neg_d;
	logic inv_q, inv_d;
	logic load;

	logic [W:0] trial;
	logic [W-1:0] rem_next;
	logic [W-1:0] total;

	assign arg_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	// one subtractor shared by every remainder step
	assign trial = {rem_q, y_q[W-1]} - {1'b0, x_q};
	assign rem_next = trial[W] ? {rem_q[W-2:0], y_q[W-1]} : trial[W-1:0];

	// common twos go back into the gcd
	assign total = y_q << twos_q;

	always_comb begin
		state_d = state_q;
		x_d = x_q;
		y_d = y_q;
		rem_d = rem_q;
		cnt_d = cnt_q;
		twos_d = twos_q;
		a8_d = a8_q;
		neg_d = neg_q;
		inv_d = inv_q;
		load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (arg_valid) begin
					x_d = arg.value_a;
					y_d = arg.value_b;
					a8_d = arg.value_a[2:0];
					twos_d = '0;
					neg_d = 1'b0;
					inv_d = (arg.value_b == OPND_ZERO);
					state_d = (arg.value_b == OPND_ZERO) ? ST_FIN : ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (!y_q[0]) begin
					y_d = y_q >> 1;
					if (a8_q == MOD8_THREE || a8_q == MOD8_FIVE) begin
						neg_d = !neg_q;
					end else if (!x_q[0]) begin
						x_d = x_q >> 1;
						twos_d = twos_q + 1'b1;
					end
				end else if (y_q == OPND_ONE || x_q == OPND_ONE) begin
					y_d = OPND_ONE;
					state_d = ST_FIN;
				end else begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (x_q == OPND_ZERO) begin
					// gcd is the odd divisor left in y
					state_d = ST_FIN;
				end else if (x_q == OPND_ONE) begin
					y_d = OPND_ONE;
					state_d = ST_FIN;
				end else if (!x_q[0]) begin
					if (y_q[2:0] == MOD8_THREE || y_q[2:0] == MOD8_FIVE) begin
						neg_d = !neg_q;
					end
					x_d = x_q >> 1;
				end else begin
					if (x_q[1:0] == MOD4_THREE && y_q[1:0] == MOD4_THREE) begin
						neg_d = !neg_q;
					end
					rem_d = '0;
					cnt_d = CNT_LAST;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				// y shifts out as the dividend, then takes the old divisor
				rem_d = rem_next;
				y_d = y_q << 1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					x_d = rem_next;
					y_d = x_q;
					state_d = ST_LOOP;
				end
			end
			ST_FIN: begin
				if (!res_valid_q || !res_stall) begin
					load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (inv_q) begin
			res_d.symbol = SYM_ZERO;
			res_d.common_divisor = OPND_ZERO;
			res_d.not_coprime = 1'b0;
			res_d.invalid = 1'b1;
		end else if (total == OPND_ONE) begin
			res_d.symbol = neg_q ? SYM_NEG : SYM_POS;
			res_d.common_divisor = OPND_ONE;
			res_d.not_coprime = 1'b0;
			res_d.invalid = 1'b0;
		end else begin
			res_d.symbol = SYM_ZERO;
			res_d.common_divisor = total;
			res_d.not_coprime = 1'b1;
			res_d.invalid = 1'b0;
		end
	end

	assign res_valid_d = load | (res_valid_q & res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_d;
		y_q <= y_d;
		rem_q <= rem_d;
		cnt_q <= cnt_d;
		twos_q <= twos_d;
		a8_q <= a8_d;
		neg_q <= neg_d;
		inv_q <= inv_d;
		if (load) begin
			res_q <= res_d;
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> x_q != OPND_ZERO)
		else $error("remainder step with zero divisor");

	a_loop_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOP |-> y_q[0])
		else $error("euclid loop with even divisor");

	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.invalid |-> res.not_coprime == (res.symbol == SYM_ZERO))
		else $error("symbol and not_coprime disagree");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && !arg_stall |=> state_q == ST_STRIP || state_q == ST_FIN)
		else $error("accepted transaction did not start work");

endmodule

[tb/tb_kronecker_symbol_or_gcd.sv]
// self-checking testbench for the kronecker symbol / gcd block
`timescale 1ns / 1ps

import ksg_pkg::*;

class symbol_scoreboard;
	ksg_res_t expected_results[$];
	int mismatches = 0;

	// kronecker symbol (a/b) when coprime, otherwise gcd with not_coprime
	function ksg_res_t kronecker_or_gcd(ksg_arg_t pair);
		logic [OPERAND_WIDTH-1:0] x, y, g, r, total;
		logic [2:0] a_mod8;
		int twos;
		bit neg;
		bit done;
		ksg_res_t res;
		res = '0;
		x = pair.value_a;
		y = pair.value_b;
		a_mod8 = x[2:0];
		twos = 0;
		neg = 1'b0;
		if (y == OPND_ZERO) begin
			res.invalid = 1'b1;
			return res;
		end
		// twos of b flip the sign by a mod 8, others shared with a go to the gcd
		while (!y[0]) begin
			y = y >> 1;
			if (a_mod8 == MOD8_THREE || a_mod8 == MOD8_FIVE)
				neg = !neg;
			else if (!x[0]) begin
				x = x >> 1;
				twos++;
			end
		end
		g = OPND_ONE;
		if (!(y == OPND_ONE || x == OPND_ONE)) begin
			done = 1'b0;
			while (!done) begin
				if (x == OPND_ZERO) begin
					g = y;
					done = 1'b1;
				end else if (x == OPND_ONE) begin
					done = 1'b1;
				end else begin
					while (!x[0]) begin
						if (y[2:0] == MOD8_THREE || y[2:0] == MOD8_FIVE)
							neg = !neg;
						x = x >> 1;
					end
					if (x == OPND_ONE) begin
						done = 1'b1;
					end else begin
						if (x[1:0] == MOD4_THREE && y[1:0] == MOD4_THREE)
							neg = !neg;
						r = y % x;
						y = x;
						x = r;
					end
				end
			end
		end
		total = g << twos;
		if (total == OPND_ONE) begin
			res.symbol = neg ? SYM_NEG : SYM_POS;
			res.common_divisor = OPND_ONE;
		end else begin
			res.symbol = SYM_ZERO;
			res.common_divisor = total;
			res.not_coprime = 1'b1;
		end
		return res;
	endfunction

	function void note_arg(ksg_arg_t pair);
		expected_results.push_back(kronecker_or_gcd(pair));
	endfunction

	function void check_res(ksg_res_t got);
		ksg_res_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result, expected none actual %h", $time, got);
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		if (got.symbol !== want.symbol) begin
			$display("%0t: symbol mismatch, expected %0d actual %0d",
				$time, want.symbol, got.symbol);
			mismatches++;
		end
		if (got.common_divisor !== want.common_divisor) begin
			$display("%0t: common_divisor mismatch, expected %0d actual %0d",
				$time, want.common_divisor, got.common_divisor);
			mismatches++;
		end
		if (got.not_coprime !== want.not_coprime) begin
			$display("%0t: not_coprime mismatch, expected %b actual %b",
				$time, want.not_coprime, got.not_coprime);
			mismatches++;
		end
		if (got.invalid !== want.invalid) begin
			$display("%0t: invalid mismatch, expected %b actual %b",
				$time, want.invalid, got.invalid);
			mismatches++;
		end
	endfunction
endclass

module tb_kronecker_symbol_or_gcd;

	localparam int HOLD_CYCLES = 2000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic arg_valid = 1'b0;
	logic arg_stall;
	ksg_arg_t arg = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ksg_res_t res;

	symbol_scoreboard sb = new();
	bit hold_req = 1'b0;
	bit quiet = 1'b0;
	int idle_cycles = 0;

	ksg_arg_t directed_pairs[23] = '{
		{32'h0000_0000, 32'h0000_0000},
		{32'hFFFF_FFFF, 32'h0000_0000},
		{32'h0000_0000, 32'h0000_0001},
		{32'h0000_0000, 32'hFFFF_FFFF},
		{32'h0000_0000, 32'h8000_0000},
		{32'h0000_0001, 32'h0000_0001},
		{32'hFFFF_FFFF, 32'hFFFF_FFFF},
		{32'hFFFF_FFFF, 32'h0000_0001},
		{32'h0000_0001, 32'hFFFF_FFFF},
		{32'd3, 32'd8},
		{32'd5, 32'd2},
		{32'd7, 32'd16},
		{32'd2, 32'd4},
		{32'd12, 32'd18},
		{32'h8000_0000, 32'h8000_0000},
		{32'd2, 32'd3},
		{32'd3, 32'd7},
		{32'd6, 32'd9},
		{32'hFFFF_FFFE, 32'hFFFF_FFFF},
		{32'h5555_5555, 32'hAAAA_AAAA},
		{32'h0000_0001, 32'h8000_0000},
		{32'd1836311903, 32'd2971215073},
		{32'd10, 32'd3}
	};

	kronecker_symbol_or_gcd u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg_valid (arg_valid),
		.arg_stall (arg_stall),
		.arg       (arg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ksg_arg_t rand_pair();
		ksg_arg_t p;
		logic [OPERAND_WIDTH-1:0] f;
		int k;
		p.value_a = $urandom;
		p.value_b = $urandom;
		case ($urandom_range(0, 9))
			3: begin
				p.value_a = $urandom_range(0, 255);
				p.value_b = $urandom_range(1, 255);
			end
			4: begin
				// shared factor, usually not coprime
				f = $urandom_range(2, 5000);
				p.value_a = f * $urandom_range(0, 60000);
				p.value_b = f * $urandom_range(1, 60000);
			end
			5: begin
				k = $urandom_range(1, 31);
				p.value_b = (p.value_b | OPND_ONE) << k;
			end
			6: begin
				p.value_a = p.value_a & $urandom;
				p.value_b = p.value_b & $urandom & $urandom;
			end
			7: begin
				p.value_a = p.value_b + $urandom_range(0, 8);
			end
			8: begin
				// even b against a that is 3 or 5 mod 8
				p.value_a[2:0] = $urandom_range(0, 1) ? MOD8_THREE : MOD8_FIVE;
				p.value_b[0] = 1'b0;
			end
			9: begin
				if ($urandom_range(0, 1))
					p.value_b = OPND_ZERO;
				else
					p.value_a = OPND_ZERO;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic pause_args(input int cycles);
		arg_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_pair(input ksg_arg_t pair, input bit gaps);
		arg <= pair;
		arg_valid <= 1'b1;
		@(posedge clk);
		while (arg_stall) @(posedge clk);
		sb.note_arg(pair);
		if (gaps && !quiet && $urandom_range(0, 3) == 0)
			pause_args($urandom_range(1, 8));
	endtask

	// result side: check each transaction, then pick the next stall value
	initial begin
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				sb.check_res(res);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (quiet) begin
				res_stall <= 1'b0;
			end else if (free_left > 0) begin
				res_stall <= 1'b0;
				free_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				stall_left = $urandom_range(1, 8) - 1;
			end else begin
				res_stall <= 1'b0;
				free_left = $urandom_range(0, 30);
			end
		end
	end

	always @(posedge clk) begin
		if ((arg_valid && !arg_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_pairs[i])
			send_pair(directed_pairs[i], 1'b1);
		repeat (400) send_pair(rand_pair(), 1'b1);
		// long receiver hold-off while pairs keep coming back to back
		hold_req = 1'b1;
		repeat (20) send_pair(rand_pair(), 1'b0);
		repeat (400) send_pair(rand_pair(), 1'b1);
		quiet = 1'b1;
		repeat (80) send_pair(rand_pair(), 1'b0);
		pause_args(1);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
